/* design/bdch_pkg.sv */
package bdch_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ACTIVE_LEVEL  = 3'd0,
    REG_DEBOUNCE      = 3'd1,
    REG_CLICK_TIMEOUT = 3'd2,
    REG_LONG_PRESS    = 3'd3,
    REG_HOLD_TICK     = 3'd4,
    REG_CLICK_EN      = 3'd5,
    REG_HOLD_EN       = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_reg_t;

  // Event codes
  typedef enum logic [1:0] {
    EV_CLICK      = 2'd0,
    EV_HOLD_START = 2'd1,
    EV_HOLD_TICK  = 2'd2,
    EV_HOLD_END   = 2'd3
  } event_kind_t;

  // Timing values used when a register holds zero (also the reset values)
  localparam logic [15:0] DEF_DEBOUNCE      = 16'd50;
  localparam logic [15:0] DEF_CLICK_TIMEOUT = 16'd300;
  localparam logic [15:0] DEF_LONG_PRESS    = 16'd1000;
  localparam logic [15:0] DEF_HOLD_TICK     = 16'd200;

  localparam logic [2:0] MAX_CLICKS = 3'd5;
  localparam logic [2:0] TALLY_CAP  = 3'd6;

endpackage

/* design/button_debounce_click_hold.sv */
// Debounce, multi-click and long-press detector for one button. Each input
// word is one poll (pin level plus a wrapping millisecond timestamp); the
// block answers each poll with zero or one event word: a click group of 1 to
// 5 clicks after the click timeout, hold start at the long-press threshold,
// periodic hold ticks, and hold end with the press duration. One poll is
// taken per clock cycle unless the block stalls; a poll is held in the
// input register, and its event is loaded into the output register when
// the poll is processed, to be taken from there. The only stall comes
// from a full output register that is not being drained. Configuration
// writes take effect at the next edge and must be made while no poll is
// in flight. A timing register that holds zero behaves as its reset value.
module button_debounce_click_hold (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // poll words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pin_level,
  input  logic [31:0] time_ms,
  // event words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [2:0]  clicks,
  output logic [31:0] press_time
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic        press_polarity;
  logic [15:0] settle_ms;
  logic [15:0] click_timeout_ms;
  logic [15:0] long_press_ms;
  logic [15:0] hold_tick_ms;
  logic        click_report_enable;
  logic        hold_report_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_polarity      <= 1'b0;
      settle_ms           <= bdch_pkg::DEF_DEBOUNCE;
      click_timeout_ms    <= bdch_pkg::DEF_CLICK_TIMEOUT;
      long_press_ms       <= bdch_pkg::DEF_LONG_PRESS;
      hold_tick_ms        <= bdch_pkg::DEF_HOLD_TICK;
      click_report_enable <= 1'b0;
      hold_report_enable  <= 1'b0;
    end else if (cfg_write) begin
      unique case (bdch_pkg::cfg_reg_t'(cfg_index))
        bdch_pkg::REG_ACTIVE_LEVEL:  press_polarity      <= cfg_data[0];
        bdch_pkg::REG_DEBOUNCE:      settle_ms           <= cfg_data;
        bdch_pkg::REG_CLICK_TIMEOUT: click_timeout_ms    <= cfg_data;
        bdch_pkg::REG_LONG_PRESS:    long_press_ms       <= cfg_data;
        bdch_pkg::REG_HOLD_TICK:     hold_tick_ms        <= cfg_data;
        bdch_pkg::REG_CLICK_EN:      click_report_enable <= cfg_data[0];
        bdch_pkg::REG_HOLD_EN:       hold_report_enable  <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Zero in a timing register means "use the default"
  logic [15:0] deb_eff, cto_eff, lp_eff, tick_eff;
  assign deb_eff  = (settle_ms == 16'd0)        ? bdch_pkg::DEF_DEBOUNCE      : settle_ms;
  assign cto_eff  = (click_timeout_ms == 16'd0) ? bdch_pkg::DEF_CLICK_TIMEOUT : click_timeout_ms;
  assign lp_eff   = (long_press_ms == 16'd0)    ? bdch_pkg::DEF_LONG_PRESS    : long_press_ms;
  assign tick_eff = (hold_tick_ms == 16'd0)     ? bdch_pkg::DEF_HOLD_TICK     : hold_tick_ms;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic        in_full;
  logic        in_pin;
  logic [31:0] in_time;
  logic        fire;   // buffered poll is processed this cycle

  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pin  <= pin_level;
      in_time <= time_ms;
    end
  end

  // ---------------------------------------------------------------------
  // Detector state
  // ---------------------------------------------------------------------
  logic        raw_prev, raw_prev_next;
  logic        stable_pressed, stable_pressed_next;
  logic [31:0] change_stamp, change_stamp_next;
  logic [31:0] press_stamp, press_stamp_next;
  logic [2:0]  click_tally, click_tally_next;
  logic        awaiting_more_clicks, awaiting_more_clicks_next;
  logic        holding, holding_next;
  logic [31:0] tick_stamp, tick_stamp_next;
  logic        hold_end_done, hold_end_done_next;

  logic        ev;
  logic [1:0]  ev_kind;
  logic [2:0]  ev_clicks;
  logic [31:0] ev_dur;

  // One poll: the stamp comparisons below chain at most through one updated
  // stamp each, and a freshly reset stamp gives a zero difference.
  always_comb begin
    logic        raw;
    logic [31:0] dur;

    raw = (in_pin == press_polarity);

    raw_prev_next             = raw_prev;
    stable_pressed_next       = stable_pressed;
    change_stamp_next         = change_stamp;
    press_stamp_next          = press_stamp;
    click_tally_next          = click_tally;
    awaiting_more_clicks_next = awaiting_more_clicks;
    holding_next              = holding;
    tick_stamp_next           = tick_stamp;
    hold_end_done_next        = hold_end_done;

    ev        = 1'b0;
    ev_kind   = bdch_pkg::EV_CLICK;
    ev_clicks = 3'd0;
    ev_dur    = 32'd0;

    // raw edge restarts the settle timer
    if (raw != raw_prev) begin
      change_stamp_next = in_time;
      raw_prev_next     = raw;
    end

    // debounced transition
    if ((in_time - change_stamp_next) >= {16'd0, deb_eff} && raw != stable_pressed) begin
      stable_pressed_next = raw;
      if (raw) begin
        press_stamp_next          = in_time;
        awaiting_more_clicks_next = 1'b0;
        holding_next              = 1'b0;
        hold_end_done_next        = 1'b0;
        tick_stamp_next           = in_time;
      end else if (holding) begin
        if (hold_report_enable && !hold_end_done) begin
          ev                 = 1'b1;
          ev_kind            = bdch_pkg::EV_HOLD_END;
          ev_dur             = in_time - press_stamp;
          click_tally_next   = 3'd0;
          hold_end_done_next = 1'b1;
        end
      end else begin
        // short press released: one more click
        if (click_tally < bdch_pkg::TALLY_CAP) begin
          click_tally_next = click_tally + 3'd1;
        end
        awaiting_more_clicks_next = 1'b1;
        change_stamp_next         = in_time;
      end
    end

    // click group timeout
    if (!stable_pressed_next && awaiting_more_clicks_next &&
        (in_time - change_stamp_next) >= {16'd0, cto_eff}) begin
      if (click_tally_next != 3'd0 && click_tally_next <= bdch_pkg::MAX_CLICKS &&
          click_report_enable && !ev) begin
        ev        = 1'b1;
        ev_kind   = bdch_pkg::EV_CLICK;
        ev_clicks = click_tally_next;
      end
      awaiting_more_clicks_next = 1'b0;
      click_tally_next          = 3'd0;
    end

    // long press and hold ticks
    dur = in_time - press_stamp_next;
    if (stable_pressed_next) begin
      if (!holding_next && dur >= {16'd0, lp_eff}) begin
        holding_next    = 1'b1;
        tick_stamp_next = in_time;
        if (hold_report_enable && !ev) begin
          ev      = 1'b1;
          ev_kind = bdch_pkg::EV_HOLD_START;
          ev_dur  = dur;
        end
      end
      if (holding_next && (in_time - tick_stamp_next) >= {16'd0, tick_eff}) begin
        if (hold_report_enable && !ev) begin
          ev      = 1'b1;
          ev_kind = bdch_pkg::EV_HOLD_TICK;
          ev_dur  = dur;
        end
        tick_stamp_next = tick_stamp_next + {16'd0, tick_eff};
      end
    end else begin
      holding_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev             <= 1'b0;
      stable_pressed       <= 1'b0;
      change_stamp         <= 32'd0;
      press_stamp          <= 32'd0;
      click_tally          <= 3'd0;
      awaiting_more_clicks <= 1'b0;
      holding              <= 1'b0;
      tick_stamp           <= 32'd0;
      hold_end_done        <= 1'b0;
    end else if (fire) begin
      raw_prev             <= raw_prev_next;
      stable_pressed       <= stable_pressed_next;
      change_stamp         <= change_stamp_next;
      press_stamp          <= press_stamp_next;
      click_tally          <= click_tally_next;
      awaiting_more_clicks <= awaiting_more_clicks_next;
      holding              <= holding_next;
      tick_stamp           <= tick_stamp_next;
      hold_end_done        <= hold_end_done_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ev) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ev) begin
      event_kind <= ev_kind;
      clicks     <= ev_clicks;
      press_time <= ev_dur;
    end
  end

endmodule
